FILE: sv/htr_pkg.sv
// Shared types and constants for the hall sensor tachometer block.
`default_nettype none

package htr_pkg;

    localparam int FRAC_BITS_DEF = 4;

    localparam int MS_PER_MIN = 60000;
    localparam int MS_W       = 16;
    localparam int RPM_W      = 20;
    localparam int EDGE_W     = 32;
    localparam int ELAP_W     = 32;
    localparam int TPR_W      = 16;
    localparam int TMO_W      = 16;

    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd10000;
    localparam logic [TPR_W-1:0] TPR_RESET     = 16'd1;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_ACTIVE_HIGH   = 2'd0;
    localparam logic [1:0] REG_TICKS_PER_REV = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_MS    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic tick;
        logic mul;
        logic div_step;
        logic rpm_write;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } t_status;

    typedef struct packed {
        logic             active_high;
        logic [TPR_W-1:0] ticks_per_rev;
        logic [TMO_W-1:0] timeout_ms;
    } t_cfg;

endpackage

`default_nettype wire

FILE: sv/htr_ctrl.sv
// Sequencer for the tachometer: tick intake, multiply, divide, result push.
`default_nettype none

module htr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic             i_out_stall,
    output logic                  o_out_valid,
    input  htr_pkg::t_status      i_status,
    output htr_pkg::t_cmd         o_cmd
);
    import htr_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.tick = 1'b1;
                    n_state    = i_status.need_div ? ST_MUL : ST_PUSH;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.rpm_write = 1'b1;
                n_state         = ST_PUSH;
            end
            ST_PUSH: begin
                if (out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        n_out_valid = o_cmd.push || (r_out_valid && i_out_stall);
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

FILE: sv/htr_datapath.sv
// Tachometer state, edge detect, period multiplier, restoring divider, output register.
`default_nettype none

module htr_datapath #(
    parameter int FRAC_BITS = htr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_pin_level,
    input  wire logic                      i_clear,
    input  htr_pkg::t_cfg                  i_cfg,
    input  htr_pkg::t_cmd                  i_cmd,
    output htr_pkg::t_status               o_status,
    output logic                           o_level_active,
    output logic                           o_changed,
    output logic                           o_active_edge,
    output logic                           o_inactive_edge,
    output logic [htr_pkg::EDGE_W-1:0]     o_edge_total,
    output logic [htr_pkg::RPM_W-1:0]      o_rpm_q4
);
    import htr_pkg::*;

    localparam int NUM_W = MS_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int QX_W  = (NUM_W > RPM_W) ? NUM_W : RPM_W;
    localparam int DEN_W = ELAP_W + TPR_W;
    localparam logic [NUM_W-1:0] NUM_VAL   = NUM_W'(MS_PER_MIN) << FRAC_BITS;
    localparam logic [QX_W-1:0]  RPM_MAX_X = QX_W'({RPM_W{1'b1}});

    // tachometer state
    logic              r_last_level,   n_last_level;
    logic [EDGE_W-1:0] r_edge_counter, n_edge_counter;
    logic [ELAP_W-1:0] r_elapsed,      n_elapsed;
    logic              r_have_prev,    n_have_prev;
    logic [RPM_W-1:0]  r_rpm,          n_rpm;

    // pending flags of the current tick
    logic r_p_level, r_p_changed, r_p_act, r_p_inact;

    // divider
    logic [ELAP_W-1:0] r_period;
    logic [DEN_W-1:0]  r_den;
    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_num;
    logic [NUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_cnt;

    // output register
    logic              r_o_level, r_o_changed, r_o_act, r_o_inact;
    logic [EDGE_W-1:0] r_o_edge_total;
    logic [RPM_W-1:0]  r_o_rpm;

    logic              level_act, changed, act, inact;
    logic [ELAP_W-1:0] elapsed_inc, elapsed_tick;
    logic              tmo_hit;
    logic [NUM_W:0]    rem_sh, rem_diff;
    logic              rem_ge;
    logic [QX_W-1:0]   q_x;
    logic [RPM_W-1:0]  rpm_sat;

    assign elapsed_inc  = (r_elapsed == '1) ? r_elapsed : r_elapsed + ELAP_W'(1);
    assign level_act    = (i_pin_level == i_cfg.active_high);
    assign changed      = (i_pin_level != r_last_level);
    assign act          = changed & level_act;
    assign inact        = changed & ~level_act;
    assign elapsed_tick = act ? '0 : elapsed_inc;
    assign tmo_hit      = (elapsed_tick >= ELAP_W'(i_cfg.timeout_ms));

    assign o_status.need_div = !i_clear && act && r_have_prev;
    assign o_status.div_last = (r_cnt == CNT_W'(1));

    // one quotient bit per step
    assign rem_sh   = {r_rem, r_num[NUM_W-1]};
    assign rem_ge   = (DEN_W'(rem_sh) >= r_den);
    assign rem_diff = rem_sh - r_den[NUM_W:0];

    assign q_x     = QX_W'(r_quo);
    assign rpm_sat = (q_x > RPM_MAX_X) ? '1 : q_x[RPM_W-1:0];

    always_comb begin
        n_last_level   = r_last_level;
        n_edge_counter = r_edge_counter;
        n_elapsed      = r_elapsed;
        n_have_prev    = r_have_prev;
        n_rpm          = r_rpm;
        if (i_cmd.tick) begin
            if (i_clear) begin
                n_last_level   = ~i_cfg.active_high;
                n_edge_counter = '0;
                n_elapsed      = '0;
                n_have_prev    = 1'b0;
                n_rpm          = '0;
            end else begin
                n_last_level = i_pin_level;
                n_elapsed    = elapsed_tick;
                if (act) begin
                    n_edge_counter = r_edge_counter + EDGE_W'(1);
                    n_have_prev    = 1'b1;
                end
                // rpm of an edge with a known period is written after the divide
                if (tmo_hit && !o_status.need_div) begin
                    n_rpm = '0;
                end
            end
        end else if (i_cmd.rpm_write) begin
            n_rpm = (i_cfg.timeout_ms == '0) ? '0 : rpm_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level   <= 1'b0;
            r_edge_counter <= '0;
            r_elapsed      <= '0;
            r_have_prev    <= 1'b0;
            r_rpm          <= '0;
        end else begin
            r_last_level   <= n_last_level;
            r_edge_counter <= n_edge_counter;
            r_elapsed      <= n_elapsed;
            r_have_prev    <= n_have_prev;
            r_rpm          <= n_rpm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick) begin
            r_p_level   <= !i_clear && level_act;
            r_p_changed <= !i_clear && changed;
            r_p_act     <= !i_clear && act;
            r_p_inact   <= !i_clear && inact;
            r_period    <= elapsed_inc;
        end
        if (i_cmd.mul) begin
            r_den <= DEN_W'(r_period) * DEN_W'(i_cfg.ticks_per_rev);
            r_rem <= '0;
            r_num <= NUM_VAL;
            r_quo <= '0;
            r_cnt <= CNT_W'(NUM_W);
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_diff[NUM_W-1:0] : rem_sh[NUM_W-1:0];
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_quo <= {r_quo[NUM_W-2:0], rem_ge};
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.push) begin
            r_o_level      <= r_p_level;
            r_o_changed    <= r_p_changed;
            r_o_act        <= r_p_act;
            r_o_inact      <= r_p_inact;
            r_o_edge_total <= r_edge_counter;
            r_o_rpm        <= r_rpm;
        end
    end

    assign o_level_active  = r_o_level;
    assign o_changed       = r_o_changed;
    assign o_active_edge   = r_o_act;
    assign o_inactive_edge = r_o_inact;
    assign o_edge_total    = r_o_edge_total;
    assign o_rpm_q4        = r_o_rpm;

endmodule

`default_nettype wire

FILE: sv/hall_tachometer_rpm_top.sv
// Top level of the hall sensor tachometer: register port, sequencer and datapath.
`default_nettype none

// Hall sensor tachometer. Each input transfer is one millisecond tick carrying the
// sampled pin level and a clear flag; each tick yields exactly one output transfer with
// the polarity-corrected level, change and edge flags, the active-edge count and the
// speed in rpm with FRAC_BITS fraction bits, truncated. Speed is recomputed on every
// active edge after the first as (60000 << FRAC_BITS) / (period_ms * ticks_per_rev),
// saturated to 20 bits, and reads zero once the milliseconds since the last active
// edge reach timeout_ms (always zero when timeout_ms is zero). A tick with clear set
// returns all zeros and restarts the state; the pin is not looked at on that tick.
// Steps: a tick without a new speed passes through intake and output load. A tick that
// produces a new speed passes through intake, the 32x16 period multiply, the restoring
// divider, which retires one quotient bit per cycle, the speed write and the output
// load. One tick is in flight at a time; the output register holds a finished result
// while the next tick is taken in. Registers (APB, byte addresses):
// 0x0 active_high, 0x4 ticks_per_rev (a write of zero is dropped), 0x8 timeout_ms.
// Register writes are meant for idle periods only.
module hall_tachometer_rpm_top #(
    parameter int FRAC_BITS = htr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // tick input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_pin_level,
    input  wire logic                          i_clear,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_level_active,
    output logic                               o_changed,
    output logic                               o_active_edge,
    output logic                               o_inactive_edge,
    output logic [htr_pkg::EDGE_W-1:0]         o_edge_total,
    output logic [htr_pkg::RPM_W-1:0]          o_rpm_q4,
    // register port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [htr_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [htr_pkg::DATA_W-1:0]    pwdata,
    output logic [htr_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);
    import htr_pkg::*;

    logic             r_active_high;
    logic [TPR_W-1:0] r_tpr;
    logic [TMO_W-1:0] r_timeout;
    logic             reg_wr;
    logic [1:0]       reg_idx;
    t_cfg             cfg;
    t_cmd             cmd;
    t_status          status;

    // --- register port: writes complete in the access cycle, no wait states
    assign pready  = 1'b1;
    assign reg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_high <= 1'b1;
            r_tpr         <= TPR_RESET;
            r_timeout     <= TIMEOUT_RESET;
        end else if (reg_wr) begin
            case (reg_idx)
                REG_ACTIVE_HIGH: begin
                    r_active_high <= pwdata[0];
                end
                REG_TICKS_PER_REV: begin
                    // zero edges per revolution makes no sense; keep the old value
                    if (pwdata[TPR_W-1:0] != '0) begin
                        r_tpr <= pwdata[TPR_W-1:0];
                    end
                end
                REG_TIMEOUT_MS: begin
                    r_timeout <= pwdata[TMO_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ACTIVE_HIGH:   prdata = DATA_W'(r_active_high);
            REG_TICKS_PER_REV: prdata = DATA_W'(r_tpr);
            REG_TIMEOUT_MS:    prdata = DATA_W'(r_timeout);
            default:           prdata = '0;
        endcase
    end

    assign cfg.active_high   = r_active_high;
    assign cfg.ticks_per_rev = r_tpr;
    assign cfg.timeout_ms    = r_timeout;

    // --- sequencer: decides when a tick is taken and walks the speed computation
    htr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // --- datapath: edge logic, counters, multiply/divide and output register
    htr_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pin_level     (i_pin_level),
        .i_clear         (i_clear),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_level_active  (o_level_active),
        .o_changed       (o_changed),
        .o_active_edge   (o_active_edge),
        .o_inactive_edge (o_inactive_edge),
        .o_edge_total    (o_edge_total),
        .o_rpm_q4        (o_rpm_q4)
    );

    // --- checks
    // one tick at a time: intake closes right after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("tick taken while previous tick still in work");

    // an edge is always a change, and never both kinds at once
    a_edge_is_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_active_edge || o_inactive_edge)) |->
            (o_changed && !(o_active_edge && o_inactive_edge)))
        else $error("edge flags inconsistent with change flag");

    // a change is classified by the new level
    a_edge_matches_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_changed) |->
            ((o_active_edge && o_level_active) || (o_inactive_edge && !o_level_active)))
        else $error("edge kind does not match level");

endmodule

`default_nettype wire

FILE: tb/hall_tachometer_rpm_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the hall tachometer: tick stimulus, register setup, speed prediction.

module hall_tachometer_rpm_top_tb;
    import htr_pkg::*;

    // Run bounds. The limit leaves room for the slowest legal tick plus handshake
    // gaps on every tick of the whole run.
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = FRAC_BITS_DEF + 28;
    localparam int HOLD_CYCLES = 300;
    localparam logic [RPM_W-1:0] RPM_SAT = '1;

    // One result transfer, field for field as the block reports it.
    typedef struct packed {
        logic              level_active;
        logic              changed;
        logic              active_edge;
        logic              inactive_edge;
        logic [EDGE_W-1:0] edge_total;
        logic [RPM_W-1:0]  rpm_q4;
    } reading_t;

    // Tracks tachometer state per accepted tick and holds the readings the
    // block still owes, oldest first.
    class rpm_tracker;
        logic              active_high;
        logic [TPR_W-1:0]  ticks_per_rev;
        logic [TMO_W-1:0]  timeout_ms;
        logic              last_level;
        logic [EDGE_W-1:0] edge_count;
        logic [ELAP_W-1:0] elapsed_ms;
        logic              have_previous;
        logic [RPM_W-1:0]  rpm_now;
        reading_t          pending_readings[$];
        int                errors, readings_checked, ticks_taken;
        int                edges, speed_updates, timeouts, clears, saturations;

        function new();
            active_high = 1'b1;
            ticks_per_rev = TPR_RESET;
            timeout_ms = TIMEOUT_RESET;
            restart();
        endfunction

        function void restart();
            last_level = ~active_high;
            edge_count = '0;
            elapsed_ms = '0;
            have_previous = 1'b0;
            rpm_now = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_ACTIVE_HIGH: active_high = value[0];
                REG_TICKS_PER_REV: begin
                    // zero is dropped by the block
                    if (value[TPR_W-1:0] != '0) ticks_per_rev = value[TPR_W-1:0];
                end
                REG_TIMEOUT_MS: timeout_ms = value[TMO_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [DATA_W-1:0] reg_value(logic [1:0] idx);
            case (idx)
                REG_ACTIVE_HIGH:   return DATA_W'(active_high);
                REG_TICKS_PER_REV: return DATA_W'(ticks_per_rev);
                default:           return DATA_W'(timeout_ms);
            endcase
        endfunction

        function void take_tick(logic pin, logic clr);
            reading_t r;
            logic [63:0] den, quot;
            r = '0;
            ticks_taken++;
            if (clr) begin
                clears++;
                restart();
            end else begin
                if (elapsed_ms != '1) elapsed_ms++;
                r.level_active = (pin == active_high);
                r.changed = (pin != last_level);
                r.active_edge = r.changed & r.level_active;
                r.inactive_edge = r.changed & ~r.level_active;
                last_level = pin;
                if (r.active_edge) begin
                    edges++;
                    edge_count++;
                    if (have_previous) begin
                        speed_updates++;
                        den = 64'(elapsed_ms) * 64'(ticks_per_rev);
                        quot = (64'(MS_PER_MIN) << FRAC_BITS_DEF) / den;
                        if (quot >= 64'(RPM_SAT)) begin
                            saturations++;
                            quot = 64'(RPM_SAT);
                        end
                        rpm_now = quot[RPM_W-1:0];
                    end
                    elapsed_ms = '0;
                    have_previous = 1'b1;
                end
                if (elapsed_ms >= ELAP_W'(timeout_ms)) begin
                    if (rpm_now != '0) timeouts++;
                    rpm_now = '0;
                end
                r.edge_total = edge_count;
                r.rpm_q4 = rpm_now;
            end
            pending_readings.push_back(r);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void match_reading(reading_t got);
            reading_t want;
            if (pending_readings.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none got %p",
                         $time, got);
                errors++;
                return;
            end
            want = pending_readings.pop_front();
            readings_checked++;
            check_field("level_active", 32'(want.level_active), 32'(got.level_active));
            check_field("changed", 32'(want.changed), 32'(got.changed));
            check_field("active_edge", 32'(want.active_edge), 32'(got.active_edge));
            check_field("inactive_edge", 32'(want.inactive_edge), 32'(got.inactive_edge));
            check_field("edge_total", want.edge_total, got.edge_total);
            check_field("rpm_q4", 32'(want.rpm_q4), 32'(got.rpm_q4));
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_pin_level = 1'b0;
    logic              i_clear = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_level_active;
    logic              o_changed;
    logic              o_active_edge;
    logic              o_inactive_edge;
    logic [EDGE_W-1:0] o_edge_total;
    logic [RPM_W-1:0]  o_rpm_q4;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    rpm_tracker tach;
    int cyc = 0;
    // Idle odds in percent per cycle for each side, set per phase.
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    // Long receiver hold-off: main flow bumps the request count, the stall
    // process serves it with its own cycle counter.
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    hall_tachometer_rpm_top u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_pin_level(i_pin_level),
        .i_clear(i_clear),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_level_active(o_level_active),
        .o_changed(o_changed),
        .o_active_edge(o_active_edge),
        .o_inactive_edge(o_inactive_edge),
        .o_edge_total(o_edge_total),
        .o_rpm_q4(o_rpm_q4),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Cycle count and hard stop.
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d readings outstanding", $time,
                     tach.pending_readings.size());
            $display("hall_tachometer_rpm_top: mismatch");
            $finish;
        end
    end

    // Result side stall: random per phase, or a long hold when requested.
    always @(posedge i_clk) begin
        if (hold_left == 0 && hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
        end
    end

    // Result monitor: a transfer happens where valid is high and stall low.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tach.match_reading({o_level_active, o_changed, o_active_edge,
                                o_inactive_edge, o_edge_total, o_rpm_q4});
        end
    end

    // Offer one tick, with random idle cycles ahead of it, and hold it until
    // the block takes the transfer.
    task automatic send_tick(input logic pin, input logic clr);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pin_level <= pin;
        i_clear <= clr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tach.take_tick(pin, clr);
    endtask

    // Stop offering and let every owed reading come back, then let the
    // block settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tach.pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup phase, access phase, then the bus goes idle again; pready is
    // tied high by the block.
    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Register write while idle, followed by a readback check.
    task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] rd, want, mask;
        drain();
        apb_access(1'b1, idx, value, rd);
        tach.set_reg(idx, value);
        apb_access(1'b0, idx, '0, rd);
        want = tach.reg_value(idx);
        mask = (idx == REG_ACTIVE_HIGH) ? 32'h1 : 32'hFFFF;
        if ((rd & mask) !== want) begin
            $display("%0t: register %0d readback expected %0d got %0d", $time, idx,
                     want, rd & mask);
            tach.errors++;
        end
    endtask

    // Square wave on the pin with random run lengths, some pin noise and the
    // odd clear. Optionally fires the long receiver hold partway through.
    task automatic run_phase(input int n_items, input int max_run, input int hold_at);
        int sent, run;
        logic lvl, pin;
        sent = 0;
        lvl = 1'($urandom_range(0, 1));
        while (sent < n_items) begin
            run = $urandom_range(1, max_run);
            for (int k = 0; k < run && sent < n_items; k++) begin
                pin = ($urandom_range(0, 99) < 8) ? 1'($urandom_range(0, 1)) : lvl;
                send_tick(pin, $urandom_range(0, 99) < 2);
                sent++;
                if (sent == hold_at) hold_requests++;
            end
            lvl = ~lvl;
        end
    endtask

    initial begin
        logic [DATA_W-1:0] junk;
        tach = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset config: polarity high, one tick per rev.
        snd_idle_pct = 37;
        rcv_idle_pct = 65;
        send_tick(1'b1, 1'b1);      // clear ignores the pin
        send_tick(1'b0, 1'b0);      // already inactive: no change
        send_tick(1'b1, 1'b0);      // first active edge, no speed yet
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);      // 2 ms period
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);      // 3 ms period
        send_tick(1'b1, 1'b1);      // clear with pin high
        send_tick(1'b1, 1'b0);      // edge right after clear
        // Flip polarity with the pin high: the next low tick is an active
        // edge 1 ms later, the fastest speed the block can report.
        cfg_write(REG_ACTIVE_HIGH, 32'hFFFF_FFFE);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        // Slowest nonzero speed, then let it time out.
        cfg_write(REG_TIMEOUT_MS, 32'hABCD_0003);
        cfg_write(REG_TICKS_PER_REV, 32'h0000_FFFF);
        send_tick(1'b0, 1'b0);
        repeat (3) send_tick(1'b0, 1'b0);
        // Zero write to ticks per rev is dropped; zero timeout pins rpm at 0.
        cfg_write(REG_TICKS_PER_REV, 32'h5A5A_0000);
        cfg_write(REG_TIMEOUT_MS, 32'h0);
        cfg_write(REG_ACTIVE_HIGH, 32'h1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);

        // Random phases; idle pattern rotates: sender 37 / receiver 65,
        // then swapped, then no idling.
        for (int p = 0; p < 6; p++) begin
            logic [TPR_W-1:0] tpr;
            logic [TMO_W-1:0] tmo;
            case (p)
                0: begin tpr = 16'd1; tmo = 16'hFFFF; end
                1: begin tpr = 16'hFFFF; tmo = 16'd20; end
                2: begin tpr = 16'($urandom_range(1, 6)); tmo = 16'($urandom_range(5, 60)); end
                3: begin tpr = 16'($urandom_range(1, 300)); tmo = 16'd1; end
                4: begin tpr = 16'($urandom_range(1, 4)); tmo = 16'($urandom_range(10, 40)); end
                default: begin
                    tpr = 16'($urandom_range(1, 65535));
                    tmo = 16'($urandom_range(1, 65535));
                end
            endcase
            cfg_write(REG_ACTIVE_HIGH, (p < 2) ? DATA_W'(p == 0) : $urandom());
            cfg_write(REG_TICKS_PER_REV, {16'($urandom()), tpr});
            cfg_write(REG_TIMEOUT_MS, {16'($urandom()), tmo});
            case (p % 3)
                0: begin snd_idle_pct = 37; rcv_idle_pct = 65; end
                1: begin snd_idle_pct = 65; rcv_idle_pct = 37; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            // Long receiver hold in phase 4 while ticks keep coming.
            run_phase(80, $urandom_range(2, 25), (p == 4) ? 10 : -1);
        end

        drain();
        junk = '0;
        apb_access(1'b0, REG_ACTIVE_HIGH, '0, junk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d ticks, %0d readings checked: %0d active edges, %0d speed updates",
                 tach.ticks_taken, tach.readings_checked, tach.edges, tach.speed_updates);
        $display("  %0d timeouts to zero, %0d at full scale, %0d clears, %0d errors",
                 tach.timeouts, tach.saturations, tach.clears, tach.errors);
        if (tach.errors == 0) begin
            $display("hall_tachometer_rpm_top: match");
        end else begin
            $display("hall_tachometer_rpm_top: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/htr_pkg.sv
sv/htr_ctrl.sv
sv/htr_datapath.sv
sv/hall_tachometer_rpm_top.sv
tb/hall_tachometer_rpm_top_tb.sv
